[rtl/rational_arithmetic_unit_assert.svh]
// Assertion macros for the rational arithmetic unit.
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RAU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rational unit: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rational unit: next-cycle check failed");

`endif

[rtl/rau_pkg.sv]
// Package of the rational arithmetic unit: beat types, mode, status and unit op codes, widths.
package rau_pkg;

    localparam int RAU_WIDTH = 32;

    localparam logic [1:0] ALU_ADD = 2'd0;
    localparam logic [1:0] ALU_SUB = 2'd1;
    localparam logic [1:0] ALU_MUL = 2'd2;

    localparam logic [2:0] MODE_ADD   = 3'd0;
    localparam logic [2:0] MODE_SUB   = 3'd1;
    localparam logic [2:0] MODE_MUL   = 3'd2;
    localparam logic [2:0] MODE_DIV   = 3'd3;
    localparam logic [2:0] MODE_CMP   = 3'd4;
    localparam logic [2:0] MODE_FLOOR = 3'd5;
    localparam logic [2:0] MODE_CEIL  = 3'd6;
    localparam logic [2:0] MODE_ROUND = 3'd7;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef struct packed {
        logic ge_u;
        logic lt_s;
    } alu_flags_t;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] a_num;
        logic [30:0]        a_den;
        logic signed [31:0] b_num;
        logic [30:0]        b_den;
    } req_t;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic [30:0]        res_den;
        logic signed [31:0] res_int;
        logic               is_less;
        logic               is_equal;
        logic [1:0]         status;
    } rsp_t;

endpackage

[rtl/rau_alu.sv]
// Shared 64-bit add, subtract and 32x32 signed multiply unit.
module rau_alu
(
    input  logic [1:0]              op,
    input  logic [63:0]             a,
    input  logic [63:0]             b,
    output logic [63:0]             y,
    output rau_pkg::alu_flags_t     flags
);

    logic [64:0]        diff;
    logic signed [63:0] prod;

    assign diff = {1'b0, a} - {1'b0, b};
    assign prod = $signed(a[31:0]) * $signed(b[31:0]);

    always_comb
    begin
        unique case (op)
            rau_pkg::ALU_ADD: y = a + b;
            rau_pkg::ALU_SUB: y = diff[63:0];
            rau_pkg::ALU_MUL: y = prod;
            default:          y = a + b;
        endcase
    end

    assign flags.ge_u = ~diff[64];
    // signs differ: a is below b exactly when a is negative
    assign flags.lt_s = (a[63] ^ b[63]) ? a[63] : diff[63];

endmodule

[rtl/rational_arithmetic_unit.sv]
// Top level of the rational arithmetic unit: sequencer around one shared unit.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-----------------------------------
//  req     | in  | req_valid, req_stall | rau_pkg::req_t (mode, a, b)
//  rsp     | out | rsp_valid, rsp_stall | rau_pkg::rsp_t (fraction, int, flags)
//
//  One beat is worked at a time; req_stall is high from acceptance until the
//  result has moved into the output register. Compare needs no division;
//  floor, ceiling and round run one 64-step restoring division, and add,
//  subtract, multiply and divide run the binary gcd loop and then two
//  64-step divisions on the shared 64-bit unit. In those four modes a zero
//  numerator skips the gcd loop and the divisions; a zero divisor or denominator goes straight to the finish state.
//  Reset clears the sequencer and the output valid; payload is not reset.
//  A result held under rsp_stall does not block the next request beat.
module rational_arithmetic_unit
#(
    parameter int WIDTH = rau_pkg::RAU_WIDTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  rau_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output rau_pkg::rsp_t rsp
);

    // Sequencer states.
    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_MUL_A    = 5'd1;
    localparam logic [4:0] S_MUL_B    = 5'd2;
    localparam logic [4:0] S_MUL_C    = 5'd3;
    localparam logic [4:0] S_COMB     = 5'd4;
    localparam logic [4:0] S_CMP      = 5'd5;
    localparam logic [4:0] S_ABS_N    = 5'd6;
    localparam logic [4:0] S_ABS_D    = 5'd7;
    localparam logic [4:0] S_GCD      = 5'd8;
    localparam logic [4:0] S_DIV_N    = 5'd9;
    localparam logic [4:0] S_DIV_D    = 5'd10;
    localparam logic [4:0] S_INT_PREP = 5'd11;
    localparam logic [4:0] S_INT_ABS  = 5'd12;
    localparam logic [4:0] S_DIV_I    = 5'd13;
    localparam logic [4:0] S_INT_ADJ  = 5'd14;
    localparam logic [4:0] S_CHECK    = 5'd15;
    localparam logic [4:0] S_FIN      = 5'd16;

    // Result limits at WIDTH bits, as 64-bit magnitudes.
    localparam logic [63:0] POS_MAX = (64'd1 << (WIDTH - 1)) - 64'd1;
    localparam logic [63:0] NEG_MAG = 64'd1 << (WIDTH - 1);
    localparam int          DIV_STEPS = 64;
    localparam int          CNT_W     = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    logic [4:0]        state_reg, state_next;
    rau_pkg::req_t     req_reg;
    logic [63:0]       p1_reg, p2_reg, p3_reg;
    logic [63:0]       x_reg, y_reg, g_reg;
    logic [5:0]        k_reg;
    logic [63:0]       mag_reg, dq_reg, q_reg, rem_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              neg_reg;
    rau_pkg::rsp_t     res_reg;
    rau_pkg::rsp_t     out_reg;
    logic              out_valid_reg;

    logic [1:0]          alu_op;
    logic [63:0]         alu_a, alu_b, alu_y;
    rau_pkg::alu_flags_t alu_flags;

    logic [63:0] an, ad, bn, bd;
    logic [2:0]  mode;
    logic        req_take;
    logic        out_free;
    logic [63:0] div_shift, rem_step, q_step;
    logic        int_mode;
    logic        ovf;

    assign mode = req_reg.mode;
    assign an   = {{32{req_reg.a_num[31]}}, req_reg.a_num};
    assign ad   = {33'd0, req_reg.a_den};
    assign bn   = {{32{req_reg.b_num[31]}}, req_reg.b_num};
    assign bd   = {33'd0, req_reg.b_den};

    assign req_stall = (state_reg != S_IDLE);
    assign req_take  = req_valid && !req_stall;
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign int_mode  = (mode == rau_pkg::MODE_FLOOR) || (mode == rau_pkg::MODE_CEIL)
                       || (mode == rau_pkg::MODE_ROUND);

    assign div_shift = {rem_reg[62:0], q_reg[63]};
    assign rem_step  = alu_flags.ge_u ? alu_y : div_shift;
    assign q_step    = {q_reg[62:0], alu_flags.ge_u};

    // Magnitude limit depends on the sign of the final value.
    assign ovf = (mag_reg > (neg_reg ? NEG_MAG : POS_MAX)) || (!int_mode && dq_reg > POS_MAX);

    rau_alu u_alu
    (
        .op    (alu_op),
        .a     (alu_a),
        .b     (alu_b),
        .y     (alu_y),
        .flags (alu_flags)
    );

    // Route operands to the shared unit.
    always_comb
    begin
        alu_op = rau_pkg::ALU_ADD;
        alu_a  = 64'd0;
        alu_b  = 64'd0;
        unique case (state_reg)
            S_MUL_A:
            begin
                alu_op = rau_pkg::ALU_MUL;
                alu_a  = an;
                alu_b  = (mode == rau_pkg::MODE_MUL) ? bn : bd;
            end
            S_MUL_B:
            begin
                alu_op = rau_pkg::ALU_MUL;
                alu_a  = ad;
                alu_b  = (mode == rau_pkg::MODE_MUL) ? bd : bn;
            end
            S_MUL_C:
            begin
                alu_op = rau_pkg::ALU_MUL;
                alu_a  = ad;
                alu_b  = bd;
            end
            S_COMB:
            begin
                alu_op = (mode == rau_pkg::MODE_SUB) ? rau_pkg::ALU_SUB : rau_pkg::ALU_ADD;
                alu_a  = p1_reg;
                alu_b  = p2_reg;
            end
            S_CMP, S_GCD:
            begin
                alu_op = rau_pkg::ALU_SUB;
                alu_a  = (state_reg == S_CMP) ? p1_reg : x_reg;
                alu_b  = (state_reg == S_CMP) ? p2_reg : y_reg;
            end
            S_ABS_N, S_INT_ABS:
            begin
                alu_op = rau_pkg::ALU_SUB;
                alu_b  = p1_reg;
            end
            S_ABS_D:
            begin
                alu_op = rau_pkg::ALU_SUB;
                alu_b  = p2_reg;
            end
            S_DIV_N, S_DIV_D, S_DIV_I:
            begin
                alu_op = rau_pkg::ALU_SUB;
                alu_a  = div_shift;
                alu_b  = g_reg;
            end
            S_INT_PREP:
            begin
                unique case (mode)
                    rau_pkg::MODE_CEIL:
                    begin
                        alu_op = rau_pkg::ALU_SUB;
                        alu_b  = an;
                    end
                    rau_pkg::MODE_ROUND:
                    begin
                        alu_a = {an[62:0], 1'b0};
                        alu_b = ad;
                    end
                    default: alu_a = an;
                endcase
            end
            S_INT_ADJ:
            begin
                alu_a = q_reg;
                alu_b = {63'd0, neg_reg && (rem_reg != 64'd0)};
            end
            S_CHECK:
            begin
                alu_op = rau_pkg::ALU_SUB;
                alu_b  = mag_reg;
            end
            default:
            begin
                alu_op = rau_pkg::ALU_ADD;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    if (req.a_den == 31'd0
                        || (req.mode <= rau_pkg::MODE_CMP && req.b_den == 31'd0)
                        || (req.mode == rau_pkg::MODE_DIV && req.b_num == 32'sd0))
                        state_next = S_FIN;
                    else if (req.mode >= rau_pkg::MODE_FLOOR)
                        state_next = S_INT_PREP;
                    else
                        state_next = S_MUL_A;
                end
            end
            S_MUL_A:    state_next = S_MUL_B;
            S_MUL_B:
            begin
                if (mode == rau_pkg::MODE_ADD || mode == rau_pkg::MODE_SUB)
                    state_next = S_MUL_C;
                else if (mode == rau_pkg::MODE_CMP)
                    state_next = S_CMP;
                else
                    state_next = S_ABS_N;
            end
            S_MUL_C:    state_next = S_COMB;
            S_COMB:     state_next = S_ABS_N;
            S_CMP:      state_next = S_FIN;
            S_ABS_N:    state_next = (p1_reg == 64'd0) ? S_FIN : S_ABS_D;
            S_ABS_D:    state_next = S_GCD;
            S_GCD:      state_next = (x_reg == 64'd0) ? S_DIV_N : S_GCD;
            S_DIV_N:    state_next = (cnt_reg == CNT_LAST) ? S_DIV_D : S_DIV_N;
            S_DIV_D:    state_next = (cnt_reg == CNT_LAST) ? S_CHECK : S_DIV_D;
            S_INT_PREP: state_next = S_INT_ABS;
            S_INT_ABS:  state_next = S_DIV_I;
            S_DIV_I:    state_next = (cnt_reg == CNT_LAST) ? S_INT_ADJ : S_DIV_I;
            S_INT_ADJ:  state_next = S_CHECK;
            S_CHECK:    state_next = S_FIN;
            S_FIN:      state_next = out_free ? S_IDLE : S_FIN;
            default:    state_next = S_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_FIN && out_free)
                out_valid_reg <= 1'b1;
            else if (!rsp_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    req_reg <= req;
                    res_reg <= '{status: rau_pkg::ST_DIV0, default: '0};
                end
            end
            S_MUL_A: p1_reg <= alu_y;
            S_MUL_B:
            begin
                p2_reg <= alu_y;
                res_reg.status <= rau_pkg::ST_OK;
            end
            S_MUL_C: p3_reg <= alu_y;
            S_COMB:
            begin
                p1_reg <= alu_y;
                p2_reg <= p3_reg;
            end
            S_CMP:
            begin
                res_reg.is_less  <= alu_flags.lt_s;
                res_reg.is_equal <= (p1_reg == p2_reg);
            end
            S_ABS_N:
            begin
                // zero numerator: give 0/1
                res_reg.res_den <= 31'd1;
                x_reg   <= p1_reg[63] ? alu_y : p1_reg;
                mag_reg <= p1_reg[63] ? alu_y : p1_reg;
                neg_reg <= p1_reg[63] ^ p2_reg[63];
            end
            S_ABS_D:
            begin
                y_reg  <= p2_reg[63] ? alu_y : p2_reg;
                dq_reg <= p2_reg[63] ? alu_y : p2_reg;
                k_reg  <= 6'd0;
            end
            S_GCD:
            begin
                if (x_reg == 64'd0)
                begin
                    g_reg   <= y_reg << k_reg;
                    q_reg   <= mag_reg;
                    rem_reg <= 64'd0;
                    cnt_reg <= '0;
                end
                else if (!x_reg[0] && !y_reg[0])
                begin
                    x_reg <= x_reg >> 1;
                    y_reg <= y_reg >> 1;
                    k_reg <= k_reg + 6'd1;
                end
                else if (!x_reg[0])
                    x_reg <= x_reg >> 1;
                else if (!y_reg[0])
                    y_reg <= y_reg >> 1;
                else if (alu_flags.ge_u)
                    x_reg <= alu_y;
                else
                begin
                    // swap so the larger is on top
                    x_reg <= y_reg;
                    y_reg <= x_reg;
                end
            end
            S_DIV_N, S_DIV_D, S_DIV_I:
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST && state_reg == S_DIV_N)
                begin
                    // numerator done: load the denominator for the second pass
                    mag_reg <= q_step;
                    q_reg   <= dq_reg;
                    rem_reg <= 64'd0;
                end
                else
                begin
                    q_reg   <= q_step;
                    rem_reg <= rem_step;
                    if (cnt_reg == CNT_LAST && state_reg == S_DIV_D)
                        dq_reg <= q_step;
                end
            end
            S_INT_PREP:
            begin
                p1_reg <= alu_y;
                g_reg  <= (mode == rau_pkg::MODE_ROUND) ? {ad[62:0], 1'b0} : ad;
                res_reg.status <= rau_pkg::ST_OK;
            end
            S_INT_ABS:
            begin
                q_reg   <= p1_reg[63] ? alu_y : p1_reg;
                neg_reg <= p1_reg[63];
                rem_reg <= 64'd0;
                cnt_reg <= '0;
            end
            S_INT_ADJ:
            begin
                mag_reg <= alu_y;
                neg_reg <= neg_reg ^ (mode == rau_pkg::MODE_CEIL);
            end
            S_CHECK:
            begin
                if (ovf)
                    res_reg <= '{status: rau_pkg::ST_OVF, default: '0};
                else if (int_mode)
                    res_reg.res_int <= neg_reg ? alu_y[31:0] : mag_reg[31:0];
                else
                begin
                    res_reg.res_num <= neg_reg ? alu_y[31:0] : mag_reg[31:0];
                    res_reg.res_den <= dq_reg[30:0];
                end
            end
            S_FIN:
            begin
                if (out_free)
                    out_reg <= res_reg;
            end
            default:
            begin
                p1_reg <= p1_reg;
            end
        endcase
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // Checks on the sequencer and the result beat.
`include "rational_arithmetic_unit_assert.svh"

    `RAU_ASSERT_NEXT(a_take_busy, clk, rst_n, req_take, req_stall)
    `RAU_ASSERT_IMPL(a_div_nonzero, clk, rst_n,
        state_reg == S_DIV_N || state_reg == S_DIV_D || state_reg == S_DIV_I,
        g_reg != 64'd0)
    `RAU_ASSERT_IMPL(a_err_clear, clk, rst_n,
        rsp_valid && (rsp.status == rau_pkg::ST_DIV0 || rsp.status == rau_pkg::ST_OVF),
        rsp.res_num == 32'sd0 && rsp.res_den == 31'd0 && rsp.res_int == 32'sd0
        && !rsp.is_less && !rsp.is_equal)

endmodule
